/* hw/rtl/bads_pkg.sv */
// Shared constants, register indexes and controller/datapath interface types.
package bads_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int DIM_W   = 13;
	localparam int POS_W   = 12;
	localparam int ADDR_W  = $clog2(MAX_WIDTH);
	localparam int SUM_W   = 32;
	localparam int CNT_W   = 2 * DIM_W;
	localparam int CH_W    = 8;
	localparam int LANES   = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TGT_W = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TGT_H = 3'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic accum;
		logic avg_start;
		logic bnd_mul;
		logic bnd_start;
		logic bnd_load;
		logic emit;
		logic emit_inv;
		logic advance;
		logic cfg_wr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sizes_ok;
		logic emit_pend;
		logic moves;
		logic div_busy;
		logic out_free;
		logic cfg_known;
	} status_t;

endpackage

/* hw/rtl/bads_divider.sv */
// Four-lane restoring divider, one quotient bit per cycle in every lane.
module bads_divider
	import bads_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SUM_W-1:0]     dividend [LANES],
	input  logic [CNT_W-1:0]     divisor  [LANES],
	output logic [SUM_W-1:0]     quotient [LANES],
	output logic                 busy
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [STEP_W-1:0] steps_q;

	assign busy = (steps_q != '0);

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= STEP_W'(SUM_W);
		end else if (busy) begin
			steps_q <= steps_q - STEP_W'(1);
		end
	end

	// One shift and trial subtract per lane each cycle.
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [SUM_W-1:0] dvd_q;
		logic [CNT_W-1:0] dvs_q;
		logic [CNT_W-1:0] rem_q;
		logic [CNT_W:0]   trial;
		logic             fits;

		assign trial = {rem_q, dvd_q[SUM_W-1]};
		assign fits  = (trial >= {1'b0, dvs_q});

		always_ff @(posedge clk) begin
			if (start) begin
				dvd_q <= dividend[l];
				dvs_q <= divisor[l];
				rem_q <= '0;
			end else if (busy) begin
				dvd_q <= {dvd_q[SUM_W-2:0], fits};
				rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
			end
		end

		assign quotient[l] = dvd_q;
	end

endmodule

/* hw/rtl/bads_datapath.sv */
// Datapath: size registers, frame position, column sum store, divider and output register.
module bads_datapath
	import bads_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic [31:0]          s_axis_tdata,   // red, green, blue, alpha
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,   // red, green, blue, alpha
	output logic                 m_axis_tlast,   // frame done
	output logic                 m_axis_tuser    // size invalid
);

	logic [DIM_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic [POS_W-1:0] src_col_q, src_row_q, out_col_q, out_row_q;
	logic [DIM_W-1:0] col_end_q, row_end_q, span_start_q, band_start_q;
	logic             band_first_q;
	logic [CH_W-1:0]  px_q [LANES];
	logic [SUM_W-1:0] rd_q [LANES];
	logic [SUM_W-1:0] sum_q [LANES];
	logic [CNT_W-1:0] count_q;
	logic             span_last_q, band_last_q, frame_last_q, emit_q;
	logic [CNT_W-1:0] prod_c_q, prod_r_q;
	logic [LANES*SUM_W-1:0] mem [MAX_WIDTH];
	logic [LANES*SUM_W-1:0] rd_word_q;
	logic             out_valid_q;
	logic [31:0]      out_data_q;
	logic             out_last_q, out_inv_q;

	logic [DIM_W-1:0] src_col_x, src_row_x, out_col_x, out_row_x;
	logic             span_first, first_px, span_last, band_last, frame_last;
	logic             col_wrap, row_wrap;
	logic [CNT_W-1:0] count_raw;
	logic [SUM_W-1:0] new_sum [LANES];
	logic [SUM_W-1:0] div_dvd [LANES];
	logic [CNT_W-1:0] div_dvs [LANES];
	logic [SUM_W-1:0] div_quo [LANES];
	logic             div_busy;
	logic [ADDR_W-1:0] addr;

	assign src_col_x = {1'b0, src_col_q};
	assign src_row_x = {1'b0, src_row_q};
	assign out_col_x = {1'b0, out_col_q};
	assign out_row_x = {1'b0, out_row_q};
	assign addr      = out_col_q[ADDR_W-1:0];

	// Size check, same rules as used to gate every pixel.
	assign status.sizes_ok = (src_w_q != '0) && (src_h_q != '0) && (tgt_w_q != '0) &&
		(tgt_h_q != '0) && (tgt_w_q <= src_w_q) && (tgt_h_q <= src_h_q) &&
		(src_w_q <= DIM_W'(MAX_WIDTH)) && (src_h_q <= DIM_W'(MAX_HEIGHT));

	assign status.emit_pend = emit_q;
	assign status.moves     = col_wrap || span_last_q;
	assign status.div_busy  = div_busy;
	assign status.out_free  = !out_valid_q || m_axis_tready;
	assign status.cfg_known = (cfg_index <= REG_TGT_H);

	// Position decode.
	assign span_first = (src_col_x == span_start_q);
	assign first_px   = band_first_q && span_first;
	assign span_last  = (src_col_x + DIM_W'(1) >= col_end_q);
	assign band_last  = (src_row_x + DIM_W'(1) >= row_end_q);
	assign frame_last = (out_col_x + DIM_W'(1) >= tgt_w_q) &&
		(out_row_x + DIM_W'(1) >= tgt_h_q);
	assign col_wrap   = (src_col_x + DIM_W'(1) >= src_w_q);
	assign row_wrap   = (src_row_x + DIM_W'(1) >= src_h_q);
	assign count_raw  = CNT_W'(col_end_q - span_start_q) * CNT_W'(row_end_q - band_start_q);

	for (genvar l = 0; l < LANES; l++) begin : g_ch
		assign rd_q[l]    = rd_word_q[l*SUM_W +: SUM_W];
		assign new_sum[l] = first_px ? SUM_W'(px_q[l]) : rd_q[l] + SUM_W'(px_q[l]);
	end

	// Column sum store, one word of four channel sums per output column.
	always_ff @(posedge clk) begin
		rd_word_q <= mem[addr];
		if (cmd.accum) begin
			mem[addr] <= {new_sum[3], new_sum[2], new_sum[1], new_sum[0]};
		end
	end

	// Pixel and per-pixel working registers.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			for (int l = 0; l < LANES; l++) begin
				px_q[l] <= s_axis_tdata[l*CH_W +: CH_W];
			end
		end
		if (cmd.accum) begin
			sum_q        <= new_sum;
			count_q      <= (count_raw == '0) ? CNT_W'(1) : count_raw;
			span_last_q  <= span_last;
			band_last_q  <= band_last;
			frame_last_q <= frame_last;
		end
		if (cmd.bnd_mul) begin
			prod_c_q <= CNT_W'(out_col_x + DIM_W'(1)) * CNT_W'(src_w_q);
			prod_r_q <= CNT_W'(out_row_x + DIM_W'(1)) * CNT_W'(src_h_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
		end else if (cmd.accum) begin
			emit_q <= span_last && band_last;
		end
	end

	// Divider operands: channel averages or the two next boundaries.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (cmd.avg_start) begin
				div_dvd[l] = sum_q[l];
				div_dvs[l] = count_q;
			end else if (l == 0) begin
				div_dvd[l] = SUM_W'(prod_c_q);
				div_dvs[l] = CNT_W'(tgt_w_q);
			end else begin
				div_dvd[l] = SUM_W'(prod_r_q);
				div_dvs[l] = CNT_W'(tgt_h_q);
			end
		end
	end

	bads_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.avg_start || cmd.bnd_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.busy     (div_busy)
	);

	// Size registers and frame position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q      <= DIM_W'(1);
			src_h_q      <= DIM_W'(1);
			tgt_w_q      <= DIM_W'(1);
			tgt_h_q      <= DIM_W'(1);
			src_col_q    <= '0;
			src_row_q    <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			col_end_q    <= DIM_W'(1);
			row_end_q    <= DIM_W'(1);
			span_start_q <= '0;
			band_start_q <= '0;
			band_first_q <= 1'b1;
		end else if (cmd.cfg_wr) begin
			case (cfg_index)
				REG_SRC_W: src_w_q <= cfg_data;
				REG_SRC_H: src_h_q <= cfg_data;
				REG_TGT_W: tgt_w_q <= cfg_data;
				REG_TGT_H: tgt_h_q <= cfg_data;
				default: ;
			endcase
			if (status.cfg_known) begin
				src_col_q    <= '0;
				src_row_q    <= '0;
				out_col_q    <= '0;
				out_row_q    <= '0;
				span_start_q <= '0;
				band_start_q <= '0;
				band_first_q <= 1'b1;
			end
		end else if (cmd.advance) begin
			if (col_wrap) begin
				src_col_q    <= '0;
				out_col_q    <= '0;
				span_start_q <= '0;
				if (row_wrap) begin
					src_row_q    <= '0;
					out_row_q    <= '0;
					band_start_q <= '0;
					band_first_q <= 1'b1;
				end else begin
					src_row_q <= src_row_q + POS_W'(1);
					if (band_last_q) begin
						out_row_q    <= out_row_q + POS_W'(1);
						band_start_q <= row_end_q;
						band_first_q <= 1'b1;
					end else begin
						band_first_q <= 1'b0;
					end
				end
			end else begin
				src_col_q <= src_col_q + POS_W'(1);
				if (span_last_q) begin
					out_col_q    <= out_col_q + POS_W'(1);
					span_start_q <= col_end_q;
				end
			end
		end else if (cmd.bnd_load) begin
			col_end_q <= (tgt_w_q == '0) ? '0 : div_quo[0][DIM_W-1:0];
			row_end_q <= (tgt_h_q == '0) ? '0 : div_quo[1][DIM_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_inv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int l = 0; l < LANES; l++) begin
				out_data_q[l*CH_W +: CH_W] <= div_quo[l][CH_W-1:0];
			end
			out_last_q <= frame_last_q;
			out_inv_q  <= 1'b0;
		end else if (cmd.emit_inv) begin
			out_data_q <= '0;
			out_last_q <= 1'b0;
			out_inv_q  <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_inv_q;

endmodule

/* hw/rtl/bads_ctrl.sv */
// Controller state machine sequencing pixel, boundary and configuration work.
module bads_ctrl
	import bads_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_axis_tvalid,
	output logic    s_axis_tready,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ACC   = 4'd1;
	localparam logic [3:0] ST_CHK   = 4'd2;
	localparam logic [3:0] ST_AVG   = 4'd3;
	localparam logic [3:0] ST_EMIT  = 4'd4;
	localparam logic [3:0] ST_ADV   = 4'd5;
	localparam logic [3:0] ST_BMUL  = 4'd6;
	localparam logic [3:0] ST_BDIV  = 4'd7;
	localparam logic [3:0] ST_BWAIT = 4'd8;
	localparam logic [3:0] ST_INV   = 4'd9;

	logic [3:0] state_q, state_d;
	logic       cfg_txn, in_txn;

	assign cfg_ready     = (state_q == ST_IDLE);
	assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_txn       = cfg_valid && cfg_ready;
	assign in_txn        = s_axis_tvalid && s_axis_tready;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cfg_txn) begin
					cmd.cfg_wr = 1'b1;
					if (status.cfg_known) begin
						state_d = ST_BMUL;
					end
				end else if (in_txn) begin
					cmd.take = 1'b1;
					state_d  = status.sizes_ok ? ST_ACC : ST_INV;
				end
			end
			ST_ACC: begin
				cmd.accum = 1'b1;
				state_d   = ST_CHK;
			end
			ST_CHK: begin
				if (status.emit_pend) begin
					cmd.avg_start = 1'b1;
					state_d       = ST_AVG;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_AVG: begin
				if (!status.div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_ADV;
				end
			end
			ST_ADV: begin
				cmd.advance = 1'b1;
				state_d     = status.moves ? ST_BMUL : ST_IDLE;
			end
			ST_BMUL: begin
				cmd.bnd_mul = 1'b1;
				state_d     = ST_BDIV;
			end
			ST_BDIV: begin
				cmd.bnd_start = 1'b1;
				state_d       = ST_BWAIT;
			end
			ST_BWAIT: begin
				if (!status.div_busy) begin
					cmd.bnd_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_INV: begin
				if (status.out_free) begin
					cmd.emit_inv = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/box_area_downsampler_rgba.sv */
// Top level of the RGBA8 area-averaging downscaler.
// Source pixels enter in raster order on the slave stream, one transaction per pixel, and
// each output pixel leaves on the master stream once the last source pixel of its area
// has arrived; tlast marks the last output pixel of a frame and tuser flags a pixel that
// was refused because the programmed sizes are unusable. Pixels are handled one at a
// time: a pixel that stays inside its output column passes through the accumulate, check
// and advance states; a pixel that ends a column span also waits while the next span and
// band boundaries come out of the shared serial divider, and a pixel that completes an
// output area also waits for the four channel averages from the same divider. A write to
// a known size register restarts the frame and holds off pixels while the first
// boundaries are computed. The column sums live in one 4096 x 128-bit store.
module box_area_downsampler_rgba
	import bads_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
	output logic                 m_axis_tlast,   // frame_done
	output logic                 m_axis_tuser,   // size_invalid
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	cmd_t    cmd;
	status_t status;

	bads_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.status        (status),
		.cmd           (cmd)
	);

	bads_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

/* dv/box_area_downsampler_rgba_tb.sv */
// Self-checking testbench for the RGBA8 area-averaging downscaler.
`timescale 1ns / 100ps

module box_area_downsampler_rgba_tb;
	import bads_pkg::*;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int SETTLE       = 120;
	localparam int RANDOM_ITEMS = 850;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [31:0] data;
		logic        last;
		logic        user;
	} pixel_out_t;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] index;
		logic [DIM_W-1:0]     value;
		logic [31:0]          pixel;
		bit                   typed;
		pixel_out_t           result;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	box_area_downsampler_rgba DUT (.*);

	// Predictor state: sizes, frame position and the per-column channel sums.
	int unsigned src_w, src_h, dst_w, dst_h;
	int unsigned src_col, src_row, out_col, out_row, span_end, band_end;
	bit          band_first;
	bit [31:0]   col_sum [0:3][0:MAX_WIDTH-1];

	pixel_out_t  expected_q [$];
	int          errors, pixels_sent, results_seen, frames_seen, invalid_seen, writes_done;
	int          cycles, hold_req, hold_seen, hold_left, stall_mode, mode_left;
	int          burst_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned split_point(int unsigned k, int unsigned size,
		int unsigned parts);
		if (parts == 0) return 0;
		return int'((longint'(k) * size) / parts);
	endfunction

	function automatic bit sizes_usable();
		if (src_w == 0 || src_h == 0 || dst_w == 0 || dst_h == 0) return 0;
		if (dst_w > src_w || dst_h > src_h) return 0;
		if (src_w > MAX_WIDTH || src_h > MAX_HEIGHT) return 0;
		return 1;
	endfunction

	function automatic void frame_restart();
		src_col    = 0;
		src_row    = 0;
		out_col    = 0;
		out_row    = 0;
		span_end   = split_point(1, src_w, dst_w);
		band_end   = split_point(1, src_h, dst_h);
		band_first = 1;
	endfunction

	function automatic void size_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		case (idx)
			REG_SRC_W: src_w = val;
			REG_SRC_H: src_h = val;
			REG_TGT_W: dst_w = val;
			REG_TGT_H: dst_h = val;
			default: return;
		endcase
		frame_restart();
	endfunction

	// Accumulates one source pixel and returns the averaged output pixel it completes.
	function automatic bit average_pixel(logic [31:0] px, output pixel_out_t res);
		int unsigned col, span_start, band_start, area;
		bit          open_span, span_last, band_last;
		res = '0;
		if (!sizes_usable()) begin
			res.user = 1'b1;
			return 1;
		end
		col        = out_col % MAX_WIDTH;
		span_start = split_point(out_col, src_w, dst_w);
		band_start = split_point(out_row, src_h, dst_h);
		open_span  = band_first && (src_col == span_start);
		for (int i = 0; i < 4; i++) begin
			if (open_span) col_sum[i][col] = px[8*i +: 8];
			else col_sum[i][col] = col_sum[i][col] + px[8*i +: 8];
		end
		span_last = (src_col + 1 >= span_end);
		band_last = (src_row + 1 >= band_end);
		average_pixel = 0;
		if (span_last && band_last) begin
			area = (span_end - span_start) * (band_end - band_start);
			if (area == 0) area = 1;
			for (int i = 0; i < 4; i++) res.data[8*i +: 8] = col_sum[i][col] / area;
			res.last = (out_col + 1 >= dst_w) && (out_row + 1 >= dst_h);
			average_pixel = 1;
		end
		// Step the raster position.
		if (src_col + 1 >= src_w) begin
			src_col  = 0;
			out_col  = 0;
			span_end = split_point(1, src_w, dst_w);
			if (src_row + 1 >= src_h) begin
				frame_restart();
			end else begin
				src_row++;
				if (band_last) begin
					out_row++;
					band_end   = split_point(out_row + 1, src_h, dst_h);
					band_first = 1;
				end else begin
					band_first = 0;
				end
			end
		end else begin
			src_col++;
			if (span_last) begin
				out_col++;
				span_end = split_point(out_col + 1, src_w, dst_w);
			end
		end
	endfunction

	// Offers one pixel in bursts with random gaps and logs its expected output.
	task automatic send_pixel(logic [31:0] px, bit typed, pixel_out_t typed_res);
		pixel_out_t res;
		int         gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
		if (average_pixel(px, res)) expected_q.push_back(typed ? typed_res : res);
		pixels_sent++;
	endtask

	// Waits until every expected output has arrived and the block has gone quiet.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_write(idx, val);
		writes_done++;
		@(posedge clk);
	endtask

	task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw, int unsigned th);
		drain();
		write_size(REG_SRC_W, DIM_W'(sw));
		write_size(REG_SRC_H, DIM_W'(sh));
		write_size(REG_TGT_W, DIM_W'(tw));
		write_size(REG_TGT_H, DIM_W'(th));
		if ($urandom_range(0, 5) == 0) write_size(3'($urandom_range(4, 7)), DIM_W'($urandom));
	endtask

	// Output side: checks each transaction and stalls on its own pattern.
	always @(posedge clk) begin
		pixel_out_t got, want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d outputs outstanding", $time, expected_q.size());
			$display("FAILURE");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected output, expected none, actual %h", $time, got);
			end else begin
				want = expected_q.pop_front();
				if (got.data !== want.data) begin
					errors++;
					$display("%0t: tdata expected %h actual %h", $time, want.data, got.data);
				end
				if (got.last !== want.last) begin
					errors++;
					$display("%0t: tlast expected %b actual %b", $time, want.last, got.last);
				end
				if (got.user !== want.user) begin
					errors++;
					$display("%0t: tuser expected %b actual %b", $time, want.user, got.user);
				end
				results_seen++;
				frames_seen  += got.last;
				invalid_seen += got.user;
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left  = $urandom_range(50, 300);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 0);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		stim_row_t   rows [$];
		pixel_out_t  none;
		int unsigned sw, sh, tw, th, count, phase, kind;
		none          = '0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		src_w = 1;
		src_h = 1;
		dst_w = 1;
		dst_h = 1;
		frame_restart();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset sizes pass pixels through, then unusable sizes, then small averages.
		rows = '{
			'{ROW_PIXEL, '0, '0, 32'h0000_0000, 1, '{32'h0000_0000, 1'b1, 1'b0}},
			'{ROW_PIXEL, '0, '0, 32'hFFFF_FFFF, 1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
			'{ROW_PIXEL, '0, '0, 32'h8040_C001, 1, '{32'h8040_C001, 1'b1, 1'b0}},
			'{ROW_WRITE, REG_TGT_W, 13'd2, '0, 0, none},
			'{ROW_PIXEL, '0, '0, 32'hA5A5_A5A5, 1, '{32'h0, 1'b0, 1'b1}},
			'{ROW_WRITE, 3'd5, 13'h1FFF, '0, 0, none},
			'{ROW_PIXEL, '0, '0, 32'h5A5A_5A5A, 1, '{32'h0, 1'b0, 1'b1}},
			'{ROW_WRITE, REG_TGT_W, 13'd0, '0, 0, none},
			'{ROW_PIXEL, '0, '0, 32'hFFFF_FFFF, 1, '{32'h0, 1'b0, 1'b1}},
			'{ROW_WRITE, REG_TGT_W, 13'd1, '0, 0, none},
			'{ROW_WRITE, REG_SRC_W, 13'h1FFF, '0, 0, none},
			'{ROW_PIXEL, '0, '0, 32'h1234_5678, 1, '{32'h0, 1'b0, 1'b1}},
			'{ROW_WRITE, REG_SRC_W, 13'd2, '0, 0, none},
			'{ROW_WRITE, REG_SRC_H, 13'd2, '0, 0, none},
			'{ROW_PIXEL, '0, '0, 32'hFFFF_FFFF, 0, none},
			'{ROW_PIXEL, '0, '0, 32'h0000_0000, 0, none},
			'{ROW_PIXEL, '0, '0, 32'hFFFF_FFFF, 0, none},
			'{ROW_PIXEL, '0, '0, 32'h0101_0101, 0, none},
			'{ROW_WRITE, 3'd7, 13'd0, '0, 0, none},
			'{ROW_WRITE, REG_SRC_W, 13'd3, '0, 0, none},
			'{ROW_WRITE, REG_TGT_W, 13'd2, '0, 0, none},
			'{ROW_WRITE, REG_SRC_H, 13'd1, '0, 0, none},
			'{ROW_PIXEL, '0, '0, 32'h10FF_2003, 0, none},
			'{ROW_PIXEL, '0, '0, 32'hF001_3004, 0, none},
			'{ROW_PIXEL, '0, '0, 32'h0FFE_4005, 0, none}
		};
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE) begin
				drain();
				write_size(rows[i].index, rows[i].value);
			end else begin
				send_pixel(rows[i].pixel, rows[i].typed, rows[i].result);
			end
		end

		// Random phases: mostly small frames, whole or cut short, some unusable, few extremes.
		phase = 0;
		while (pixels_sent < RANDOM_ITEMS + rows.size()) begin
			kind = $urandom_range(0, 99);
			// The held-off phase passes every pixel straight through so results pile up.
			if (phase == 3) kind = 8;
			if (kind < 8) begin
				sw = $urandom_range(1, 20);
				sh = $urandom_range(1, 20);
				tw = ($urandom_range(0, 1) != 0) ? sw + $urandom_range(1, 3) : sw;
				th = (tw == sw) ? sh + 1 : $urandom_range(1, sh);
				count = $urandom_range(1, 6);
			end else if (kind < 12) begin
				sw = MAX_WIDTH;
				sh = MAX_HEIGHT;
				tw = MAX_WIDTH;
				th = MAX_HEIGHT;
				count = $urandom_range(20, 60);
			end else if (kind < 15) begin
				sw = MAX_WIDTH;
				sh = $urandom_range(1, 2);
				tw = $urandom_range(1, MAX_WIDTH);
				th = 1;
				count = $urandom_range(30, 120);
			end else begin
				sw = $urandom_range(1, 12);
				sh = $urandom_range(1, 6);
				tw = $urandom_range(1, sw);
				th = $urandom_range(1, sh);
				count = sw * sh * $urandom_range(1, 3);
				if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
			end
			set_sizes(sw, sh, tw, th);
			// Hold the output side off once so the block backs up into its input.
			if (phase == 3) hold_req++;
			for (int n = 0; n < count && pixels_sent < RANDOM_ITEMS + rows.size(); n++)
				send_pixel($urandom, 0, none);
			phase++;
		end

		drain();
		$display("Sent %0d pixels over %0d register writes; %0d outputs checked,", pixels_sent,
			writes_done, results_seen);
		$display("%0d of them closing a frame and %0d refused for unusable sizes.", frames_seen,
			invalid_seen);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
